### src/bscc_pkg.sv
// ---------------------------------------------------------------------------
// bscc_pkg: shared types, constants and microcode for the binary search block
// Table sizing, control word layout and the read-only sequencer program.
// ---------------------------------------------------------------------------
package bscc_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ULEN_W      = 5;
   localparam int LIM_W       = (LEN_W > ULEN_W) ? LEN_W : ULEN_W;
   localparam int CNT_W       = 6;
   localparam int FIDX_W      = 4;
   localparam int DATA_W      = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W-1:0]  COUNT_MAX         = 6'd63;
   localparam logic [ULEN_W-1:0] USED_LENGTH_RESET = 5'd16;

   // register index of used_length
   localparam logic REG_USED_LENGTH = 1'b0;

   // request opcodes
   localparam logic OPC_WRITE  = 1'b0;
   localparam logic OPC_SEARCH = 1'b1;

   typedef logic [1:0] bscc_step_type;

   localparam bscc_step_type STEP_WAIT    = 2'd0;
   localparam bscc_step_type STEP_PROBE   = 2'd1;
   localparam bscc_step_type STEP_COMPARE = 2'd2;
   localparam bscc_step_type STEP_EMIT    = 2'd3;

   typedef enum logic [1:0] {
      OP_ACCEPT,
      OP_PROBE,
      OP_COMPARE,
      OP_EMIT
   } bscc_op_type;

   typedef enum logic [1:0] {
      COND_SEARCH,
      COND_IN_RANGE,
      COND_HIT,
      COND_OUT_FREE
   } bscc_cond_type;

   typedef struct packed {
      logic          req_ready;
      bscc_op_type   op;
      bscc_cond_type cond;
      bscc_step_type jump;
      bscc_step_type next;
   } bscc_uword_type;

   // sequencer to datapath
   typedef struct packed {
      logic        req_ready;
      bscc_op_type op;
   } bscc_ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic search_req;
      logic in_range;
      logic hit_now;
      logic out_free;
   } bscc_stat_type;

   // Microcode program: jump when the condition holds, else go to next.
   function automatic bscc_uword_type microcode(input bscc_step_type step);
      bscc_uword_type w;
      case (step)
         STEP_WAIT:    w = '{1'b1, OP_ACCEPT,  COND_SEARCH,   STEP_PROBE, STEP_WAIT};
         STEP_PROBE:   w = '{1'b0, OP_PROBE,   COND_IN_RANGE, STEP_COMPARE, STEP_EMIT};
         STEP_COMPARE: w = '{1'b0, OP_COMPARE, COND_HIT,      STEP_EMIT, STEP_PROBE};
         STEP_EMIT:    w = '{1'b0, OP_EMIT,    COND_OUT_FREE, STEP_WAIT, STEP_EMIT};
         default:      w = '{1'b0, OP_EMIT,    COND_OUT_FREE, STEP_WAIT, STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

### src/bscc_if.sv
// ---------------------------------------------------------------------------
// bscc_if: request and response channels of the binary search block
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface bscc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [3:0]                     slot_index;
   logic signed [31:0]             item_value;

   modport source (output valid, output opcode, output slot_index, output item_value,
                   input ready);
   modport sink   (input valid, input opcode, input slot_index, input item_value,
                   output ready);
endinterface

interface bscc_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [3:0] found_index;
   logic [5:0] comparisons;

   modport source (output valid, output found, output found_index, output comparisons,
                   input ready);
   modport sink   (input valid, input found, input found_index, input comparisons,
                   output ready);
endinterface

### src/bscc_sequencer.sv
// ---------------------------------------------------------------------------
// bscc_sequencer: step counter and microcode table
// Fetches one control word per step and branches on datapath status.
// ---------------------------------------------------------------------------
module bscc_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  bscc_pkg::bscc_stat_type stat,
   output bscc_pkg::bscc_ctrl_type ctrl
);
   import bscc_pkg::*;

   bscc_step_type  step_ff;
   bscc_step_type  step_in;
   bscc_uword_type uword;
   logic           take;

   // fetch the control word of the current step
   assign uword = microcode(step_ff);

   // evaluate the branch condition
   always_comb begin
      case (uword.cond)
         COND_SEARCH:   take = stat.search_req;
         COND_IN_RANGE: take = stat.in_range;
         COND_HIT:      take = stat.hit_now;
         COND_OUT_FREE: take = stat.out_free;
         default:       take = 1'b0;
      endcase
   end

   // pick the next step
   always_comb begin
      step_in = take ? uword.jump : uword.next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   // drive the datapath
   always_comb begin
      ctrl.req_ready = uword.req_ready;
      ctrl.op        = uword.op;
   end

endmodule

### src/bscc_datapath.sv
// ---------------------------------------------------------------------------
// bscc_datapath: value table, search bounds, comparison count, response register
// Executes the operation named by the current control word.
// ---------------------------------------------------------------------------
module bscc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  bscc_pkg::bscc_ctrl_type        ctrl,
   output bscc_pkg::bscc_stat_type        stat,
   input  logic [bscc_pkg::ULEN_W-1:0]    used_length,
   bscc_req_if.sink                       req_chan,
   bscc_rsp_if.source                     rsp_chan
);
   import bscc_pkg::*;

   logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic signed [DATA_W-1:0] key_ff;
   logic [LEN_W-1:0]         lo_ff;
   logic [LEN_W-1:0]         hi_ff;
   logic [IDX_W-1:0]         mid_ff;
   logic [IDX_W-1:0]         where_ff;
   logic                     hit_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [FIDX_W-1:0]        rsp_index_ff;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic [LEN_W-1:0]         len_sat;
   logic [LEN_W-1:0]         span;
   logic [LEN_W-1:0]         mid_full;
   logic [CNT_W-1:0]         count_plus1;
   logic [CNT_W-1:0]         count_plus2;
   logic                     accept;
   logic                     key_eq;
   logic                     key_gt;

   assign req_chan.ready = ctrl.req_ready;
   assign accept         = req_chan.valid && ctrl.req_ready;

   // clamp the search length to the table depth
   always_comb begin
      if (LIM_W'(used_length) > LIM_W'(TABLE_DEPTH)) begin
         len_sat = LEN_W'(TABLE_DEPTH);
      end else begin
         len_sat = LEN_W'(used_length);
      end
   end

   // midpoint of the half-open range [lo, hi)
   always_comb begin
      span     = hi_ff - lo_ff - LEN_W'(1);
      mid_full = lo_ff + (span >> 1);
   end

   // saturating comparison count
   always_comb begin
      count_plus1 = (count_ff == COUNT_MAX) ? count_ff : count_ff + CNT_W'(1);
      count_plus2 = (count_plus1 == COUNT_MAX) ? count_plus1 : count_plus1 + CNT_W'(1);
   end

   assign key_eq = (rd_data_ff == key_ff);
   assign key_gt = (rd_data_ff < key_ff);

   // status back to the sequencer
   always_comb begin
      stat.search_req = req_chan.valid && (req_chan.opcode == OPC_SEARCH);
      stat.in_range   = (lo_ff < hi_ff);
      stat.hit_now    = key_eq;
      stat.out_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   // table write and registered probe read
   always_ff @(posedge clock) begin
      if ((ctrl.op == OP_ACCEPT) && accept && (req_chan.opcode == OPC_WRITE) &&
          (int'(req_chan.slot_index) < TABLE_DEPTH)) begin
         table_mem[IDX_W'(req_chan.slot_index)] <= req_chan.item_value;
      end
      if (ctrl.op == OP_PROBE) begin
         rd_data_ff <= table_mem[mid_full[IDX_W-1:0]];
      end
   end

   // search bounds, key, hit flag and count
   always_ff @(posedge clock) begin
      case (ctrl.op)
         OP_ACCEPT: begin
            if (accept && (req_chan.opcode == OPC_SEARCH)) begin
               key_ff   <= req_chan.item_value;
               lo_ff    <= '0;
               hi_ff    <= len_sat;
               count_ff <= '0;
               hit_ff   <= 1'b0;
               where_ff <= '0;
            end
         end
         OP_PROBE: begin
            mid_ff <= mid_full[IDX_W-1:0];
         end
         OP_COMPARE: begin
            if (key_eq) begin
               hit_ff   <= 1'b1;
               where_ff <= mid_ff;
               count_ff <= count_plus1;
            end else begin
               count_ff <= count_plus2;
               if (key_gt) begin
                  lo_ff <= LEN_W'(mid_ff) + LEN_W'(1);
               end else begin
                  hi_ff <= LEN_W'(mid_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctrl.op == OP_EMIT) && stat.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((ctrl.op == OP_EMIT) && stat.out_free) begin
         rsp_found_ff <= hit_ff;
         rsp_index_ff <= hit_ff ? FIDX_W'(where_ff) : '0;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.found_index = rsp_index_ff;
   assign rsp_chan.comparisons = rsp_count_ff;

endmodule

### src/binary_search_with_compare_count_top.sv
// ---------------------------------------------------------------------------
// binary_search_with_compare_count_top: sorted table with binary search
// Write requests store a value at a slot; search requests return one
// response with hit flag, index and the number of comparisons made.
//
// Usage:
//   req_chan carries opcode, slot_index and item_value. A write request is
//   taken in the wait step and gives no response. A search request makes P
//   probes before its response is loaded into the response register, where
//   P is the number of probes (at most floor(log2(used_length)) + 1, so 5
//   for 16 entries). Each probe is a two-step loop of the microcode: issue
//   the table read at the midpoint, then compare the registered read data
//   and narrow the range. One request is worked on at a time.
//   rsp_chan holds the response in a register; while the receiver stalls
//   the block still accepts writes and starts the next search, which waits
//   in its final step until the response register is free.
//   The csr_ port sets used_length (byte address 0, reset 16, clamped to the
//   table depth); write it only while the block is idle.
//   Reset returns the sequencer to its wait step, empties the response
//   register and restores used_length. Table contents are undefined until
//   written.
// ---------------------------------------------------------------------------
module binary_search_with_compare_count_top (
   input  logic                              clock,
   input  logic                              reset,
   bscc_req_if.sink                          req_chan,
   bscc_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bscc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bscc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bscc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import bscc_pkg::*;

   bscc_ctrl_type     ctrl;
   bscc_stat_type     stat;
   logic [ULEN_W-1:0] used_length_ff;
   logic              csr_wr;

   // register file: one register at byte address 0
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_length_ff <= USED_LENGTH_RESET;
      end else if (csr_wr && (csr_paddr[2] == REG_USED_LENGTH)) begin
         used_length_ff <= csr_pwdata[ULEN_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_USED_LENGTH) begin
         csr_prdata = CSR_DATA_W'(used_length_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   bscc_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   bscc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .stat        (stat),
      .used_length (used_length_ff),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

endmodule

### src/bscc_checker.sv
// ---------------------------------------------------------------------------
// bscc_checker: port-level checks for the binary search block
// Watches the response channel and reset behavior at the top level.
// ---------------------------------------------------------------------------
module bscc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_found,
   input logic [3:0] rsp_found_index,
   input logic [5:0] rsp_comparisons
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_found_index) && $stable(rsp_comparisons))
      else $error("response changed while stalled");

   // a miss reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_index == 4'd0)
      else $error("miss with nonzero index");

   // a hit ends on an equality test, so its count is odd; a miss is even
   a_count_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_comparisons[0] == rsp_found)
      else $error("comparison count parity mismatch");

   // after reset the block waits for a request with no response pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind binary_search_with_compare_count_top bscc_checker u_bscc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_found_index (rsp_chan.found_index),
   .rsp_comparisons (rsp_chan.comparisons)
);

### sim/binary_search_with_compare_count_top_tb.sv
// ---------------------------------------------------------------------------
// binary_search_with_compare_count_top_tb: self-checking bench for the search block
// Loads sorted tables through write requests, runs searches under several
// used_length settings and idle mixes, and checks each response (hit flag,
// index, comparison count) against an in-bench binary search predictor.
// ---------------------------------------------------------------------------
module binary_search_with_compare_count_top_tb;
   import bscc_pkg::*;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 600;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CSR_ADDR_W-1:0] USED_LENGTH_ADDR = CSR_ADDR_W'(4 * REG_USED_LENGTH);

   typedef struct packed {
      logic              found;
      logic [FIDX_W-1:0] found_index;
      logic [CNT_W-1:0]  comparisons;
   } search_result_type;

   logic clock = 1'b0;
   logic reset;

   bscc_req_if req_chan ();
   bscc_rsp_if rsp_chan ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow state of the block
   logic signed [DATA_W-1:0] stored_values [TABLE_DEPTH];
   logic [ULEN_W-1:0]        length_setting;
   search_result_type        outstanding_results [$];

   int src_idle_pct  = 19;
   int sink_idle_pct = 80;
   int mismatch_count;
   int n_writes;
   int n_searches;
   int n_hits;
   int n_checked;
   int n_length_settings;
   int idle_cycles;

   binary_search_with_compare_count_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Number of leading entries a search covers, saturated at the table depth
   function automatic int searched_span();
      return (int'(length_setting) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_setting);
   endfunction

   // Binary search over the shadow table, counting equality and less-than tests
   function automatic search_result_type search_outcome(input logic signed [DATA_W-1:0] key);
      search_result_type res;
      int                lo;
      int                hi;
      int                mid;
      res = '0;
      lo  = 0;
      hi  = searched_span() - 1;
      while (lo <= hi && !res.found) begin
         mid = lo + (hi - lo) / 2;
         if (res.comparisons < COUNT_MAX) res.comparisons = res.comparisons + 1'b1;
         if (stored_values[mid] == key) begin
            res.found       = 1'b1;
            res.found_index = FIDX_W'(mid);
         end else begin
            if (res.comparisons < COUNT_MAX) res.comparisons = res.comparisons + 1'b1;
            if (stored_values[mid] < key) lo = mid + 1;
            else hi = mid - 1;
         end
      end
      return res;
   endfunction

   // Pick a search key: table hits, near misses, extremes and noise
   function automatic logic signed [DATA_W-1:0] pick_key();
      int span;
      int slot;
      span = searched_span();
      slot = (span > 0) ? int'($urandom_range(span - 1)) : 0;
      case ($urandom_range(7))
         0, 1, 2: return stored_values[slot];
         3:       return stored_values[slot] + 1;
         4:       return stored_values[slot] - 1;
         5:       return ($urandom_range(1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request, idling at random first; update the shadow on acceptance
   task automatic send_request(input logic opcode, input logic [3:0] slot,
                               input logic signed [DATA_W-1:0] value);
      search_result_type res;
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.opcode     <= opcode;
      req_chan.slot_index <= slot;
      req_chan.item_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      if (opcode == OPC_WRITE) begin
         if (int'(slot) < TABLE_DEPTH) stored_values[slot] = value;
         n_writes++;
      end else begin
         res = search_outcome(value);
         outstanding_results.push_back(res);
         n_searches++;
         if (res.found) n_hits++;
      end
      @(negedge clock);
   endtask

   // Drop valid and hold until every outstanding response has arrived
   task automatic wait_for_responses();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (outstanding_results.size() != 0);
   endtask

   // Write used_length over the APB port once the block has gone idle
   task automatic write_used_length(input int length);
      wait_for_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= USED_LENGTH_ADDR;
      csr_pwdata  <= CSR_DATA_W'(length);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      length_setting = ULEN_W'(length);
      n_length_settings++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Fill all slots with a fresh ascending table; spread picks the value range
   task automatic load_sorted_values(input int spread);
      logic signed [DATA_W-1:0] fresh [TABLE_DEPTH];
      logic signed [DATA_W-1:0] held;
      int                       j;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         case (spread)
            0:       fresh[i] = $urandom;
            1:       fresh[i] = int'($urandom_range(16)) - 8;
            default: fresh[i] = (i < TABLE_DEPTH / 2) ? 32'sh80000000 + $urandom_range(20)
                                                      : 32'sh7fffffff - $urandom_range(20);
         endcase
      end
      // insertion sort, ascending
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         held = fresh[i];
         j    = i - 1;
         while (j >= 0 && fresh[j] > held) begin
            fresh[j + 1] = fresh[j];
            j--;
         end
         fresh[j + 1] = held;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) send_request(OPC_WRITE, 4'(i), fresh[i]);
   endtask

   // Extreme values at both ends, hits at ends and middle, misses in the gaps
   task automatic test_directed_extremes();
      logic signed [DATA_W-1:0] ladder [TABLE_DEPTH] = '{
         32'sh80000000, -32'sd1073741824, -32'sd1000, -32'sd7, -32'sd1, 32'sd0, 32'sd1,
         32'sd5, 32'sd9, 32'sd100, 32'sd4096, 32'sd65535, 32'sd1048576, 32'sd1073741824,
         32'sh7ffffffe, 32'sh7fffffff};
      logic signed [DATA_W-1:0] keys [9] = '{
         32'sh80000000, 32'sh7fffffff, 32'sd0, 32'sd5, 32'sh7ffffffe,
         32'sd2, -32'sd2, 32'sh80000001, 32'sh7ffffffd};
      for (int i = 0; i < TABLE_DEPTH; i++) send_request(OPC_WRITE, 4'(i), ladder[i]);
      foreach (keys[k]) send_request(OPC_SEARCH, 4'(k), keys[k]);
   endtask

   // Sweep used_length: empty range, tiny ranges, saturation above depth, full
   task automatic test_length_settings();
      int lengths [8] = '{0, 1, 2, 3, 31, 17, 7, 16};
      foreach (lengths[n]) begin
         write_used_length(lengths[n]);
         for (int i = 0; i < searched_span(); i++)
            send_request(OPC_SEARCH, 4'($urandom_range(15)), stored_values[i]);
         repeat (4) send_request(OPC_SEARCH, 4'($urandom_range(15)), pick_key());
      end
   endtask

   // Mostly searches on freshly sorted tables, with length changes, stray
   // writes that break the ordering, and pauses until the block drains
   task automatic test_random_searches(input int quota);
      int stop_at;
      int roll;
      stop_at = n_writes + n_searches + quota;
      while (n_writes + n_searches < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            case ($urandom_range(4))
               0:       write_used_length(0);
               1:       write_used_length(31);
               2:       write_used_length(16);
               default: write_used_length($urandom_range(31));
            endcase
         end else if (roll < 7) begin
            load_sorted_values($urandom_range(2));
         end else if (roll < 9) begin
            send_request(OPC_WRITE, 4'($urandom_range(15)), $urandom);
         end else if (roll < 11) begin
            wait_for_responses();
         end else begin
            send_request(OPC_SEARCH, 4'($urandom_range(15)), pick_key());
         end
      end
   endtask

   // Receiver: stall at random, set by the current idle mix
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   // Compare each response with the oldest outstanding prediction
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_checked++;
         if (outstanding_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display({"ERROR: response with no search outstanding ",
                         "(found=%0d index=%0d count=%0d)"},
                        rsp_chan.found, rsp_chan.found_index, rsp_chan.comparisons);
         end else begin
            want = outstanding_results.pop_front();
            if (rsp_chan.found !== want.found || rsp_chan.found_index !== want.found_index ||
                rsp_chan.comparisons !== want.comparisons) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"ERROR: response %0d: found %0d/%0d index %0d/%0d ",
                            "count %0d/%0d (exp/act)"},
                           n_checked, want.found, rsp_chan.found, want.found_index,
                           rsp_chan.found_index, want.comparisons, rsp_chan.comparisons);
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d responses outstanding",
                  idle_cycles, outstanding_results.size());
         $display("** binary_search_with_compare_count_top: FAILED **");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = OPC_WRITE;
      req_chan.slot_index = '0;
      req_chan.item_value = '0;
      rsp_chan.ready      = 1'b0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      length_setting      = USED_LENGTH_RESET;
      foreach (stored_values[i]) stored_values[i] = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_extremes();
      test_length_settings();

      // sender light, receiver heavy; then swapped; then no idling
      test_random_searches(RANDOM_ITEMS / 3);
      src_idle_pct  = 80;
      sink_idle_pct = 19;
      test_random_searches(RANDOM_ITEMS / 3);
      src_idle_pct  = 0;
      sink_idle_pct = 0;
      test_random_searches(RANDOM_ITEMS / 3);

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d table writes and %0d searches (%0d hits, %0d misses)",
               n_writes, n_searches, n_hits, n_searches - n_hits);
      $display("Checked %0d responses over %0d used_length writes and three idle mixes",
               n_checked, n_length_settings);
      if (mismatch_count == 0 && outstanding_results.size() == 0) begin
         $display("** binary_search_with_compare_count_top: PASSED **");
      end else begin
         $display("** binary_search_with_compare_count_top: FAILED **");
      end
      $finish;
   end

endmodule
